/* sv/ihex_pkg.sv */
// Shared types, codes and character helpers for the Intel HEX record decoder.
`timescale 1ns / 1ps

package ihex_pkg;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_ERROR = 2'd1;
    localparam logic [1:0] KIND_EOF   = 2'd2;

    // Record types that are understood
    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;
    localparam logic [7:0] REC_BASE = 8'h04;

    localparam logic [7:0] CHAR_COLON = 8'h3A;

    // Digits per field
    localparam logic [2:0] NIB_SHORT = 3'd2;
    localparam logic [2:0] NIB_LONG  = 3'd4;

    // Line parser phase, one-hot
    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_LEN   = 7'b0000010,
        PH_OFS   = 7'b0000100,
        PH_TYPE  = 7'b0001000,
        PH_DATA  = 7'b0010000,
        PH_BASE  = 7'b0100000,
        PH_TRAIL = 7'b1000000
    } t_phase;

    // One result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] byte_address;
        logic [7:0]  data_byte;
    } t_result;

    // Space, tab, LF, VT, FF or CR
    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Hex digit in either case
    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    // Digit value; only meaningful where is_hex holds
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c <= 8'h46) begin
            v = c - 8'h37;
        end else begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

endpackage

/* sv/ihex_out_buf.sv */
// Two-entry output buffer that parts the decoder from the result channel.
`timescale 1ns / 1ps

module ihex_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ihex_pkg::t_result i_data,
    output logic              o_full,
    output logic              o_valid,
    output ihex_pkg::t_result o_data,
    input  logic              i_stall
);
    import ihex_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_take;
    logic    load_out;

    assign out_take = r_out_valid && !i_stall;
    assign load_out = out_take || !r_out_valid;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= r_skid_valid && i_push;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload: the skid entry drains first to keep order
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out  <= r_skid_valid ? r_skid : i_data;
            r_skid <= i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

/* sv/intel_hex_record_decoder_core.sv */
// Top level of the Intel HEX record decoder: character parser and result channel.
`timescale 1ns / 1ps

// Takes Intel HEX text one character per transaction and one transaction per clock
// cycle while o_stall is low; each character is decoded in the cycle it is
// accepted and gives at most one result (data byte with its 32-bit address, format
// error, or end-of-file). Results leave through a two-entry output buffer, so
// input keeps flowing while a result waits; o_stall rises only while both entries
// hold results. After an error the decoder stays silent until reset.

module intel_hex_record_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_in,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [31:0] o_byte_address,
    output logic [7:0]  o_data_byte
);
    import ihex_pkg::*;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_nib, n_nib;
    logic [15:0] r_acc, n_acc;
    logic [7:0]  r_len, n_len;
    logic [15:0] r_ofs, n_ofs;
    logic [7:0]  r_kind, n_kind;
    logic [7:0]  r_done, n_done;
    logic [15:0] r_base, n_base;
    logic        r_failed, n_failed;

    logic        in_fire;
    logic        buf_full;
    logic        res_valid;
    t_result     res;
    t_result     out_res;
    logic [15:0] acc_shift;
    logic [2:0]  nib_inc;
    logic [2:0]  need;
    logic [31:0] addr;

    assign o_stall = buf_full;
    assign in_fire = i_valid && !buf_full;

    assign acc_shift = {r_acc[11:0], hex_value(i_char_in)};
    assign nib_inc   = r_nib + 3'd1;
    assign need      = (r_phase == PH_OFS || r_phase == PH_BASE) ? NIB_LONG : NIB_SHORT;
    assign addr      = {r_base, 16'h0000} + {16'h0000, r_ofs} + {24'h000000, r_done};

    // Per-character parse step
    always_comb begin
        n_phase  = r_phase;
        n_nib    = r_nib;
        n_acc    = r_acc;
        n_len    = r_len;
        n_ofs    = r_ofs;
        n_kind   = r_kind;
        n_done   = r_done;
        n_base   = r_base;
        n_failed = r_failed;
        res_valid = 1'b0;
        res       = '{kind: KIND_DATA, byte_address: 32'h0, data_byte: 8'h00};

        if (!r_failed) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (!is_space(i_char_in)) begin
                        if (i_char_in == CHAR_COLON) begin
                            n_phase = PH_LEN;
                            n_nib   = 3'd0;
                            n_acc   = 16'h0000;
                        end else begin
                            n_failed  = 1'b1;
                            res_valid = 1'b1;
                            res.kind  = KIND_ERROR;
                        end
                    end
                end
                PH_TRAIL: begin
                    if (is_space(i_char_in)) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_LEN, PH_OFS, PH_TYPE, PH_DATA, PH_BASE: begin
                    if (is_space(i_char_in) || !is_hex(i_char_in)) begin
                        n_failed  = 1'b1;
                        res_valid = 1'b1;
                        res.kind  = KIND_ERROR;
                    end else if (nib_inc < need) begin
                        n_acc = acc_shift;
                        n_nib = nib_inc;
                    end else begin
                        // field complete
                        n_acc = 16'h0000;
                        n_nib = 3'd0;
                        unique case (r_phase)
                            PH_LEN: begin
                                n_len   = acc_shift[7:0];
                                n_phase = PH_OFS;
                            end
                            PH_OFS: begin
                                n_ofs   = acc_shift;
                                n_phase = PH_TYPE;
                            end
                            PH_TYPE: begin
                                n_kind = acc_shift[7:0];
                                priority if (acc_shift[7:0] == REC_DATA) begin
                                    n_done  = 8'h00;
                                    n_phase = (r_len != 8'h00) ? PH_DATA : PH_TRAIL;
                                end else if (acc_shift[7:0] == REC_BASE) begin
                                    n_phase = PH_BASE;
                                end else if (acc_shift[7:0] == REC_EOF) begin
                                    n_phase   = PH_TRAIL;
                                    res_valid = 1'b1;
                                    res.kind  = KIND_EOF;
                                end else begin
                                    n_failed  = 1'b1;
                                    res_valid = 1'b1;
                                    res.kind  = KIND_ERROR;
                                end
                            end
                            PH_DATA: begin
                                n_done = r_done + 8'd1;
                                if (n_done == r_len) begin
                                    n_phase = PH_TRAIL;
                                end
                                res_valid        = 1'b1;
                                res.kind         = KIND_DATA;
                                res.byte_address = addr;
                                res.data_byte    = acc_shift[7:0];
                            end
                            default: begin
                                // base record
                                n_base  = acc_shift;
                                n_phase = PH_TRAIL;
                            end
                        endcase
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_nib    <= 3'd0;
            r_acc    <= 16'h0000;
            r_len    <= 8'h00;
            r_ofs    <= 16'h0000;
            r_kind   <= 8'h00;
            r_done   <= 8'h00;
            r_base   <= 16'h0000;
            r_failed <= 1'b0;
        end else if (in_fire) begin
            r_phase  <= n_phase;
            r_nib    <= n_nib;
            r_acc    <= n_acc;
            r_len    <= n_len;
            r_ofs    <= n_ofs;
            r_kind   <= n_kind;
            r_done   <= n_done;
            r_base   <= n_base;
            r_failed <= n_failed;
        end
    end

    // Result buffer
    ihex_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_fire && res_valid),
        .i_data  (res),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .o_data  (out_res),
        .i_stall (i_stall)
    );

    assign o_kind         = out_res.kind;
    assign o_byte_address = out_res.byte_address;
    assign o_data_byte    = out_res.data_byte;

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the Intel HEX record decoder core.
`timescale 1ns / 1ps

module testbench;
    import ihex_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_CHARS  = 780;
    localparam int DRAIN_CYCLES  = 16;
    localparam int REPORT_LIMIT  = 10;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_fill;
    typedef enum int {ERR_NO_COLON, ERR_BAD_DIGIT, ERR_EARLY_END, ERR_BAD_TYPE} t_fault;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_char_in;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_kind;
    logic [31:0] o_byte_address;
    logic [7:0]  o_data_byte;

    intel_hex_record_decoder_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_char_in      (i_char_in),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_byte_address (o_byte_address),
        .o_data_byte    (o_data_byte)
    );

    // Clock, 10 ns period
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shared run state
    t_result pending_results[$];
    int      mismatch_count = 0;
    int      cycle_count    = 0;
    int      active_chars   = 0;
    logic    idle_on        = 1'b1;

    // Decoder state as predicted
    t_phase      phase      = PH_IDLE;
    logic [2:0]  nib_count  = '0;
    logic [15:0] field_acc  = '0;
    logic [7:0]  rec_len    = '0;
    logic [15:0] rec_ofs    = '0;
    logic [7:0]  rec_type   = '0;
    logic [7:0]  byte_idx   = '0;
    logic [15:0] upper_base = '0;
    logic        halted     = 1'b0;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // -1 for anything that is not a hex digit
    function automatic int digit_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        return -1;
    endfunction

    function automatic void push_result(input logic [1:0] kind, input logic [31:0] addr,
                                        input logic [7:0] data);
        t_result r;
        r.kind         = kind;
        r.byte_address = addr;
        r.data_byte    = data;
        pending_results = {pending_results, r};
    endfunction

    function automatic void flag_error();
        halted = 1'b1;
        push_result(KIND_ERROR, '0, '0);
    endfunction

    // Advance the predicted decoder by one accepted character
    function automatic void decode_char(input logic [7:0] c);
        int          v;
        logic [2:0]  need;
        logic [15:0] value;
        if (halted) return;
        if (phase == PH_IDLE) begin
            if (is_blank(c)) return;
            if (c != CHAR_COLON) begin
                flag_error();
                return;
            end
            active_chars++;
            phase     = PH_LEN;
            nib_count = '0;
            field_acc = '0;
            return;
        end
        if (phase == PH_TRAIL) begin
            if (is_blank(c)) phase = PH_IDLE;
            return;
        end
        // inside a field: blanks and non-digits both end the run
        active_chars++;
        v = digit_of(c);
        if (v < 0) begin
            flag_error();
            return;
        end
        field_acc = {field_acc[11:0], v[3:0]};
        nib_count = nib_count + 3'd1;
        need = (phase == PH_OFS || phase == PH_BASE) ? NIB_LONG : NIB_SHORT;
        if (nib_count < need) return;
        value     = field_acc;
        nib_count = '0;
        field_acc = '0;
        case (phase)
            PH_LEN: begin
                rec_len = value[7:0];
                phase   = PH_OFS;
            end
            PH_OFS: begin
                rec_ofs = value;
                phase   = PH_TYPE;
            end
            PH_TYPE: begin
                rec_type = value[7:0];
                if (rec_type == REC_DATA) begin
                    byte_idx = '0;
                    phase    = (rec_len != 8'd0) ? PH_DATA : PH_TRAIL;
                end else if (rec_type == REC_BASE) begin
                    phase = PH_BASE;
                end else if (rec_type == REC_EOF) begin
                    phase = PH_TRAIL;
                    push_result(KIND_EOF, '0, '0);
                end else begin
                    flag_error();
                end
            end
            PH_DATA: begin
                push_result(KIND_DATA, {upper_base, 16'h0000} + {16'h0000, rec_ofs} +
                            {24'h000000, byte_idx}, value[7:0]);
                byte_idx = byte_idx + 8'd1;
                if (byte_idx == rec_len) phase = PH_TRAIL;
            end
            default: begin
                upper_base = value;
                phase      = PH_TRAIL;
            end
        endcase
    endfunction

    // One character transaction; inputs move on the falling edge
    task automatic send_char(input logic [7:0] c);
        @(negedge i_clk);
        while (idle_on && $urandom_range(99) < 35) begin
            i_valid   <= 1'b0;
            i_char_in <= 8'($urandom);
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_char_in <= c;
        do @(posedge i_clk); while (o_stall);
        decode_char(c);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_char(s[k]);
    endtask

    // Hex digits, most significant first, case chosen per digit
    task automatic send_hex(input logic [15:0] value, input int digits);
        logic [3:0] nib;
        logic [7:0] ch;
        for (int k = digits - 1; k >= 0; k--) begin
            nib = value[4*k +: 4];
            if (nib < 4'd10) ch = 8'("0") + 8'(nib);
            else if ($urandom_range(1) == 1) ch = 8'("A") + 8'(nib) - 8'd10;
            else ch = 8'("a") + 8'(nib) - 8'd10;
            send_char(ch);
        end
    endtask

    function automatic logic [7:0] blank_char();
        logic [7:0] set [6] = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
        return set[$urandom_range(5)];
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do c = 8'($urandom); while (is_blank(c));
        return c;
    endfunction

    task automatic send_blanks(input int n);
        repeat (n) send_char(blank_char());
    endtask

    // One whole record line, random checksum, optional trailing junk and separator
    task automatic send_record(input logic [7:0] len, input logic [15:0] ofs,
                               input logic [7:0] rtype, input logic [15:0] base_val,
                               input t_fill fill);
        logic [7:0] b;
        send_blanks($urandom_range(0, 1));
        send_char(CHAR_COLON);
        send_hex(16'(len), 2);
        send_hex(ofs, 4);
        send_hex(16'(rtype), 2);
        if (rtype == REC_DATA) begin
            for (int k = 0; k < int'(len); k++) begin
                case (fill)
                    FILL_ZERO: b = 8'h00;
                    FILL_ONES: b = 8'hFF;
                    default:   b = 8'($urandom);
                endcase
                send_hex(16'(b), 2);
            end
        end else if (rtype == REC_BASE) begin
            send_hex(base_val, 4);
        end
        send_hex(16'($urandom), 2);
        if ($urandom_range(9) == 0) repeat ($urandom_range(1, 4)) send_char(junk_char());
        send_blanks($urandom_range(1, 3));
    endtask

    // Known records covering field extremes, address wrap and ignored text
    task automatic test_directed_records();
        send_record(8'h01, 16'h0000, REC_DATA, 16'h0000, FILL_ZERO);
        send_record(8'h02, 16'hFFFF, REC_DATA, 16'h0000, FILL_ONES);
        // base record setting the upper address to FFFF; length field matches its payload
        send_record(8'h02, 16'h0000, REC_BASE, 16'hFFFF, FILL_RANDOM);
        send_record(8'h03, 16'hFFFE, REC_DATA, 16'h0000, FILL_RANDOM);
        send_record(8'h00, 16'h1234, REC_DATA, 16'h0000, FILL_RANDOM);
        send_record(8'h00, 16'h0000, REC_EOF, 16'h0000, FILL_RANDOM);
        // colon and letters after the last field are ignored
        send_text(":01002000a5ff:x:\t");
        send_text(" \t\r\n\v\f");
        send_record(8'h00, 16'h0000, REC_BASE, 16'h0000, FILL_RANDOM);
        send_record(8'hFF, 16'hFF80, REC_DATA, 16'h0000, FILL_RANDOM);
    endtask

    // Well-formed random records; the middle stretch runs without idling
    task automatic test_random_records(input int target);
        int          start_count;
        int          pick;
        logic [7:0]  len;
        logic [15:0] ofs;
        logic [15:0] base_val;
        start_count = active_chars;
        while (active_chars - start_count < target) begin
            idle_on = !((active_chars - start_count) > target / 3 &&
                        (active_chars - start_count) < 2 * target / 3);
            pick = $urandom_range(99);
            len  = ($urandom_range(39) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
            ofs  = ($urandom_range(4) == 0) ? 16'hFFFF - 16'($urandom_range(0, 8))
                                            : 16'($urandom);
            case ($urandom_range(3))
                0:       base_val = 16'hFFFF;
                1:       base_val = 16'h0000;
                default: base_val = 16'($urandom);
            endcase
            if (pick < 65) send_record(len, ofs, REC_DATA, 16'h0000, FILL_RANDOM);
            else if (pick < 80) send_record(len, ofs, REC_BASE, base_val, FILL_RANDOM);
            else if (pick < 90) send_record(len, ofs, REC_EOF, 16'h0000, FILL_RANDOM);
            else send_blanks($urandom_range(1, 4));
        end
        idle_on = 1'b1;
    endtask

    // One format error of a random sort, then any text must stay silent
    task automatic test_error_then_silence();
        t_fault     fault;
        logic [7:0] c;
        logic [7:0] rtype;
        fault = t_fault'($urandom_range(3));
        case (fault)
            ERR_NO_COLON: begin
                do c = junk_char(); while (c == CHAR_COLON);
                send_char(c);
            end
            ERR_BAD_TYPE: begin
                do rtype = 8'($urandom);
                while (rtype == REC_DATA || rtype == REC_EOF || rtype == REC_BASE);
                send_char(CHAR_COLON);
                send_hex(16'($urandom), 2);
                send_hex(16'($urandom), 4);
                send_hex(16'(rtype), 2);
            end
            default: begin
                send_char(CHAR_COLON);
                case ($urandom_range(2))
                    0: repeat ($urandom_range(0, 7)) send_hex(16'($urandom), 1);
                    1: begin
                        send_hex(16'h0002, 2);
                        send_hex(16'($urandom), 4);
                        send_hex(16'(REC_DATA), 2);
                        repeat ($urandom_range(0, 3)) send_hex(16'($urandom), 1);
                    end
                    default: begin
                        send_hex(16'($urandom), 2);
                        send_hex(16'($urandom), 4);
                        send_hex(16'(REC_BASE), 2);
                        repeat ($urandom_range(0, 3)) send_hex(16'($urandom), 1);
                    end
                endcase
                if (fault == ERR_EARLY_END) begin
                    c = blank_char();
                end else begin
                    do c = 8'($urandom); while (is_blank(c) || digit_of(c) >= 0);
                end
                send_char(c);
            end
        endcase
        repeat (80) send_char(8'($urandom));
    endtask

    function automatic void note_mismatch(input string what, input t_result want,
                                          input t_result got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%s: expected kind %0d addr %08h data %02h, got kind %0d addr %08h data %02h",
                     what, want.kind, want.byte_address, want.data_byte,
                     got.kind, got.byte_address, got.data_byte);
    endfunction

    // Result channel: sample on the rising edge, check and stall on the falling edge
    initial begin : result_monitor
        t_result got;
        t_result want;
        logic    seen;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            seen = i_rst_n && o_valid && !i_stall;
            got  = {o_kind, o_byte_address, o_data_byte};
            @(negedge i_clk);
            if (seen) begin
                if (pending_results.size() == 0) begin
                    note_mismatch("unexpected result", '0, got);
                end else begin
                    want = pending_results.pop_front();
                    if (got.kind != want.kind || got.byte_address != want.byte_address ||
                        got.data_byte != want.data_byte)
                        note_mismatch("result mismatch", want, got);
                end
            end
            i_stall <= idle_on && ($urandom_range(99) < 35);
        end
    end

    // Test sequence
    initial begin
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_char_in = 8'h00;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_records();
        test_random_records(RANDOM_CHARS);
        test_error_then_silence();

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        mismatch_count += pending_results.size();
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/ihex_pkg.sv
sv/ihex_out_buf.sv
sv/intel_hex_record_decoder_core.sv
sim/testbench.sv
